// ===== design/flash_fs_node_framer_macros.svh =====
// ----------------------------------------------------------------------------
// flash_fs_node_framer_macros.svh
// assertion macros used by the node framer top level
// ----------------------------------------------------------------------------
`ifndef FLASH_FS_NODE_FRAMER_MACROS_SVH
`define FLASH_FS_NODE_FRAMER_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define FFNF_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("node framer check failed");

// next-cycle implication, sampled on clock, off during reset
`define FFNF_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("node framer check failed");

`endif

// ===== design/ffnf_pkg.sv =====
// ----------------------------------------------------------------------------
// ffnf_pkg
// shared constants, types and helpers of the flash node framer
// ----------------------------------------------------------------------------
package ffnf_pkg;

   // field widths
   localparam int OffWidth   = 21;
   localparam int LenWidth   = 22;
   localparam int TypeWidth  = 8;
   localparam int SeqWidth   = 64;
   localparam int ClassWidth = 2;
   localparam int StartWidth = 19;
   localparam int WordWidth  = 64;
   // wide scratch width for byte offset sums
   localparam int SumWidth   = 34;

   // defaults
   localparam int DefaultMaxBlockWords = 262144;
   localparam logic [LenWidth-1:0] DefaultBlockBytes = 22'd126976;

   // header constants
   localparam logic [31:0] HdrMagic = 32'h0610_1831;
   localparam logic [31:0] HdrBytes = 32'd24;
   localparam logic [31:0] MinInode = 32'd160;
   localparam logic [31:0] MinDentry = 32'd56;
   localparam logic [31:0] MinData  = 32'd48;
   localparam logic [StartWidth-1:0] IdxMask = 19'h7FFFF;

   // node type codes
   localparam logic [TypeWidth-1:0] TypeInode  = 8'd0;
   localparam logic [TypeWidth-1:0] TypeData   = 8'd1;
   localparam logic [TypeWidth-1:0] TypeDentry = 8'd2;

   // node class codes
   localparam logic [ClassWidth-1:0] ClassInode  = 2'd0;
   localparam logic [ClassWidth-1:0] ClassData   = 2'd1;
   localparam logic [ClassWidth-1:0] ClassDentry = 2'd2;
   localparam logic [ClassWidth-1:0] ClassOther  = 2'd3;

   // header check result handed to the top level
   typedef struct packed {
      logic                  update_next;
      logic [StartWidth-1:0] next_start;
      logic                  found;
      logic [OffWidth-1:0]   offset;
      logic [LenWidth-1:0]   length;
      logic [TypeWidth-1:0]  hdr_type;
      logic [ClassWidth-1:0] node_class;
   } check_type;

   // class from type byte and full length field
   function automatic logic [ClassWidth-1:0] classify(
      input logic [TypeWidth-1:0] hdr_type,
      input logic [31:0]          len
   );
      logic [ClassWidth-1:0] cls;
      cls = ClassOther;
      if (hdr_type == TypeInode && len >= MinInode) begin
         cls = ClassInode;
      end else if (hdr_type == TypeData && len >= MinData) begin
         cls = ClassData;
      end else if (hdr_type == TypeDentry && len >= MinDentry) begin
         cls = ClassDentry;
      end
      return cls;
   endfunction

endpackage

// ===== design/ffnf_header_check.sv =====
// ----------------------------------------------------------------------------
// ffnf_header_check
// checks the header candidate two words back and computes the next start
// ----------------------------------------------------------------------------
module ffnf_header_check #(
   parameter int CountWidth = 19
) (
   input  logic [CountWidth-1:0]          word_index,
   input  logic [ffnf_pkg::StartWidth-1:0] next_start,
   input  logic [ffnf_pkg::LenWidth-1:0]  block_bytes,
   input  logic [31:0]                    magic_word,
   input  logic [ffnf_pkg::WordWidth-1:0] cur_word,
   output ffnf_pkg::check_type            check
);

   localparam int SW = ffnf_pkg::SumWidth;

   logic [CountWidth-1:0] start_word;
   logic [SW-1:0]         start_wide;
   logic [SW-1:0]         start_byte;
   logic [SW-1:0]         bytes_wide;
   logic [31:0]           len;
   logic [SW-1:0]         len_wide;
   logic [SW-1:0]         skip_sum;
   logic [SW-1:0]         step_sum;
   logic                  check_en;
   logic                  good;

   // candidate start position
   always_comb begin
      start_word = word_index - CountWidth'(2);
      start_wide = SW'(start_word);
      start_byte = start_wide << 3;
      bytes_wide = SW'(block_bytes);
      len        = cur_word[31:0];
      len_wide   = SW'(len);
   end

   // header window open and fits, then field checks
   always_comb begin
      check_en = (word_index >= CountWidth'(2))
               && (start_wide >= SW'(next_start))
               && (start_byte + SW'(ffnf_pkg::HdrBytes) <= bytes_wide);
      good     = (magic_word == ffnf_pkg::HdrMagic)
               && (len >= ffnf_pkg::HdrBytes)
               && (start_byte + len_wide <= bytes_wide);
   end

   // next start: skip rounded length on a match, else one word
   always_comb begin
      skip_sum = start_wide + ((len_wide + SW'(7)) >> 3);
      step_sum = start_wide + SW'(1);
   end

   always_comb begin
      check.update_next = check_en;
      check.found       = check_en && good;
      if (good) begin
         if (skip_sum > SW'(ffnf_pkg::IdxMask)) begin
            check.next_start = ffnf_pkg::IdxMask;
         end else begin
            check.next_start = skip_sum[ffnf_pkg::StartWidth-1:0];
         end
      end else begin
         check.next_start = step_sum[ffnf_pkg::StartWidth-1:0];
      end
      check.offset     = start_byte[ffnf_pkg::OffWidth-1:0];
      check.length     = len[ffnf_pkg::LenWidth-1:0];
      check.hdr_type   = cur_word[39:32];
      check.node_class = ffnf_pkg::classify(cur_word[39:32], len);
   end

endmodule

// ===== design/flash_fs_node_framer.sv =====
// ----------------------------------------------------------------------------
// flash_fs_node_framer
// scans a logical erase block word stream for filesystem node headers
// ----------------------------------------------------------------------------
//  channel | direction | payload
//  req_    | in        | data_word, block_start
//  rsp_    | out       | offset, length, type byte, sequence number, class
//  csr_    | in        | block_bytes
//
// One word per cycle while req_ready is high; a header is reported in the
// cycle after its third word is taken, from a single result register fed by
// the header compare and adders. Synchronous reset clears counters, window
// and result valid; block_bytes returns to its default. A stalled result
// stalls req_ready only if the result register is full and rsp_ready is low.
// ----------------------------------------------------------------------------
`include "flash_fs_node_framer_macros.svh"

module flash_fs_node_framer #(
   parameter int MAX_BLOCK_WORDS = ffnf_pkg::DefaultMaxBlockWords
) (
   input  logic                            clock,
   input  logic                            reset,
   // request
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [ffnf_pkg::WordWidth-1:0]  req_data_word,
   input  logic                            req_block_start,
   // response
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [ffnf_pkg::OffWidth-1:0]   rsp_node_offset,
   output logic [ffnf_pkg::LenWidth-1:0]   rsp_node_length,
   output logic [ffnf_pkg::TypeWidth-1:0]  rsp_node_type,
   output logic [ffnf_pkg::SeqWidth-1:0]   rsp_sequence_number,
   output logic [ffnf_pkg::ClassWidth-1:0] rsp_node_class,
   // configuration
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [ffnf_pkg::LenWidth-1:0]   csr_block_bytes
);

   localparam int CountWidth = $clog2(MAX_BLOCK_WORDS + 1);
   localparam logic [CountWidth-1:0] MaxWords = CountWidth'(MAX_BLOCK_WORDS);

   logic [ffnf_pkg::LenWidth-1:0]   block_bytes_ff;
   logic [ffnf_pkg::WordWidth-1:0]  held_old_ff, held_old_in;
   logic [ffnf_pkg::WordWidth-1:0]  held_new_ff, held_new_in;
   logic [CountWidth-1:0]           word_count_ff, word_count_in;
   logic [ffnf_pkg::StartWidth-1:0] next_start_ff, next_start_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [ffnf_pkg::OffWidth-1:0]   offset_ff;
   logic [ffnf_pkg::LenWidth-1:0]   length_ff;
   logic [ffnf_pkg::TypeWidth-1:0]  type_ff;
   logic [ffnf_pkg::SeqWidth-1:0]   seq_ff;
   logic [ffnf_pkg::ClassWidth-1:0] class_ff;

   logic                            req_take;
   logic [CountWidth-1:0]           word_eff;
   logic [ffnf_pkg::StartWidth-1:0] start_eff;
   logic                            in_range;
   logic                            hit;
   ffnf_pkg::check_type             check;

   // handshakes
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_take  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // block start restarts counters before the check
   always_comb begin
      word_eff  = req_block_start ? '0 : word_count_ff;
      start_eff = req_block_start ? '0 : next_start_ff;
      in_range  = word_eff < MaxWords;
   end

   ffnf_header_check #(
      .CountWidth (CountWidth)
   ) u_check (
      .word_index  (word_eff),
      .next_start  (start_eff),
      .block_bytes (block_bytes_ff),
      .magic_word  (held_old_ff[31:0]),
      .cur_word    (req_data_word),
      .check       (check)
   );

   assign hit = req_take && in_range && check.found;

   // scan state next values
   always_comb begin
      word_count_in = word_count_ff;
      next_start_in = next_start_ff;
      held_old_in   = held_old_ff;
      held_new_in   = held_new_ff;
      if (req_take) begin
         word_count_in = word_eff;
         next_start_in = start_eff;
         if (in_range) begin
            word_count_in = word_eff + CountWidth'(1);
            held_old_in   = held_new_ff;
            held_new_in   = req_data_word;
            if (check.update_next) begin
               next_start_in = check.next_start;
            end
         end
      end
   end

   // result valid: set on a hit, cleared once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (hit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         block_bytes_ff <= ffnf_pkg::DefaultBlockBytes;
         held_old_ff    <= '0;
         held_new_ff    <= '0;
         word_count_ff  <= '0;
         next_start_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            block_bytes_ff <= csr_block_bytes;
         end
         held_old_ff   <= held_old_in;
         held_new_ff   <= held_new_in;
         word_count_ff <= word_count_in;
         next_start_ff <= next_start_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (hit) begin
         offset_ff <= check.offset;
         length_ff <= check.length;
         type_ff   <= check.hdr_type;
         seq_ff    <= held_new_ff;
         class_ff  <= check.node_class;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_node_offset     = offset_ff;
   assign rsp_node_length     = length_ff;
   assign rsp_node_type       = type_ff;
   assign rsp_sequence_number = seq_ff;
   assign rsp_node_class      = class_ff;

   // assertions
   `FFNF_ASSERT_IMPL(a_count_bound, 1'b1, word_count_ff <= MaxWords)
   `FFNF_ASSERT_IMPL(a_min_length, rsp_valid_ff, length_ff >= ffnf_pkg::LenWidth'(24))
   `FFNF_ASSERT_IMPL(a_inode_class, rsp_valid_ff && class_ff == ffnf_pkg::ClassInode,
      type_ff == ffnf_pkg::TypeInode && length_ff >= ffnf_pkg::LenWidth'(160))
   `FFNF_ASSERT_NEXT(a_block_restart, req_take && req_block_start,
      word_count_ff == CountWidth'(1))

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the flash filesystem node framer
// ----------------------------------------------------------------------------
// Streams erase block words into the framer and predicts every node header
// report from its own model of the scan window, word counter and skip target.
// A directed opening covers the class thresholds, a failed magic followed by a
// real header, short and runaway lengths and a stream with no block start.
// Dedicated blocks then cover the smallest block, a saturating skip in an
// oversized block and a full-size block filled by a single node.
// Random phases follow at several block sizes, mostly well-formed node chains
// with some broken headers and noise. Both sides idle at random, and the
// response side holds off once for a long stretch so the framer backs up.
// ----------------------------------------------------------------------------
module tb;
   import ffnf_pkg::*;

   localparam int MaxWords = DefaultMaxBlockWords;

   // one node header report
   typedef struct packed {
      logic [OffWidth-1:0]   offset;
      logic [LenWidth-1:0]   length;
      logic [TypeWidth-1:0]  hdr_type;
      logic [SeqWidth-1:0]   sequence_number;
      logic [ClassWidth-1:0] node_class;
   } node_record_type;

   // scan model and store of node reports still to arrive
   class node_scoreboard;
      logic [LenWidth-1:0]   block_bytes;
      logic [WordWidth-1:0]  older_word;
      logic [WordWidth-1:0]  newer_word;
      logic [StartWidth-1:0] word_index;
      logic [StartWidth-1:0] next_start;
      node_record_type       expected_nodes[$];
      int                    mismatches;

      function new();
         block_bytes = DefaultBlockBytes;
         older_word  = '0;
         newer_word  = '0;
         word_index  = '0;
         next_start  = '0;
         mismatches  = 0;
      endfunction

      function void set_block_bytes(logic [LenWidth-1:0] value);
         block_bytes = value;
      endfunction

      function int pending();
         return expected_nodes.size();
      endfunction

      // take one accepted word and queue the header report it completes
      function void scan_word(logic [WordWidth-1:0] word, logic first);
         logic [63:0]          start_word;
         logic [63:0]          start_byte;
         logic [63:0]          len;
         logic [63:0]          skip_to;
         logic [TypeWidth-1:0] ty;
         node_record_type      node;
         if (first) begin
            word_index = '0;
            next_start = '0;
         end
         // words beyond the block word limit are dropped
         if (word_index >= MaxWords) return;
         if (word_index >= 2) begin
            start_word = 64'(word_index - 19'd2);
            start_byte = start_word << 3;
            if (start_word >= 64'(next_start) &&
                start_byte + 64'(HdrBytes) <= 64'(block_bytes)) begin
               len = 64'(word[31:0]);
               ty  = word[39:32];
               if (older_word[31:0] == HdrMagic && len >= 64'(HdrBytes) &&
                   start_byte + len <= 64'(block_bytes)) begin
                  node.offset          = start_byte[OffWidth-1:0];
                  node.length          = len[LenWidth-1:0];
                  node.hdr_type        = ty;
                  node.sequence_number = newer_word;
                  if (ty == TypeInode && len >= 64'(MinInode)) begin
                     node.node_class = ClassInode;
                  end else if (ty == TypeData && len >= 64'(MinData)) begin
                     node.node_class = ClassData;
                  end else if (ty == TypeDentry && len >= 64'(MinDentry)) begin
                     node.node_class = ClassDentry;
                  end else begin
                     node.node_class = ClassOther;
                  end
                  expected_nodes.push_back(node);
                  // skip the whole node, pinned at the top of the index range
                  skip_to = start_word + ((len + 64'd7) >> 3);
                  next_start = (skip_to > 64'(IdxMask)) ? IdxMask : skip_to[StartWidth-1:0];
               end else begin
                  next_start = start_word[StartWidth-1:0] + 19'd1;
               end
            end
         end
         older_word = newer_word;
         newer_word = word;
         word_index = word_index + 19'd1;
      endfunction

      function void compare_field(string name, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
         end
      endfunction

      // compare one accepted report with the oldest prediction
      function void check_node(node_record_type seen);
         node_record_type want;
         if (expected_nodes.size() == 0) begin
            $display("%0t: unexpected node report, expected none, actual offset %0h length %0h",
                     $time, seen.offset, seen.length);
            mismatches++;
            return;
         end
         want = expected_nodes.pop_front();
         compare_field("node_offset", 64'(want.offset), 64'(seen.offset));
         compare_field("node_length", 64'(want.length), 64'(seen.length));
         compare_field("hdr_type", 64'(want.hdr_type), 64'(seen.hdr_type));
         compare_field("sequence_number", want.sequence_number, seen.sequence_number);
         compare_field("node_class", 64'(want.node_class), 64'(seen.node_class));
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [WordWidth-1:0]  req_data_word;
   logic                  req_block_start;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [OffWidth-1:0]   rsp_node_offset;
   logic [LenWidth-1:0]   rsp_node_length;
   logic [TypeWidth-1:0]  rsp_node_type;
   logic [SeqWidth-1:0]   rsp_sequence_number;
   logic [ClassWidth-1:0] rsp_node_class;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [LenWidth-1:0]   csr_block_bytes;

   node_scoreboard sb = new();
   bit             idle_on;
   bit             hold_rsp;

   flash_fs_node_framer u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_data_word       (req_data_word),
      .req_block_start     (req_block_start),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_node_offset     (rsp_node_offset),
      .rsp_node_length     (rsp_node_length),
      .rsp_node_type       (rsp_node_type),
      .rsp_sequence_number (rsp_sequence_number),
      .rsp_node_class      (rsp_node_class),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_block_bytes     (csr_block_bytes)
   );

   always #6 clock = ~clock;

   // watch every transaction on the three channels
   always @(posedge clock) begin : watch
      node_record_type seen;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            seen.offset          = rsp_node_offset;
            seen.length          = rsp_node_length;
            seen.hdr_type        = rsp_node_type;
            seen.sequence_number = rsp_sequence_number;
            seen.node_class      = rsp_node_class;
            sb.check_node(seen);
         end
         if (req_valid && req_ready) begin
            sb.scan_word(req_data_word, req_block_start);
         end
         if (csr_valid && csr_ready) begin
            sb.set_block_bytes(csr_block_bytes);
         end
      end
   end

   // response side: random stalls, one long hold-off on request
   initial begin : rsp_side
      int stall;
      rsp_ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            stall = 300;
         end else begin
            stall = idle_on ? $urandom_range(0, 9) : 0;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (reset || !(rsp_valid && rsp_ready)) @(posedge clock);
      end
   end

   // length word: random filler above the type byte
   function automatic logic [63:0] len_word(logic [TypeWidth-1:0] ty, logic [31:0] len);
      return {24'($urandom), ty, len};
   endfunction

   // offer one word after a random gap and wait for its transaction
   task automatic send_word(input logic [63:0] word, input logic first);
      int gap;
      gap = idle_on ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_data_word   <= word;
      req_block_start <= first;
      @(posedge clock);
      while (!(req_valid && req_ready)) @(posedge clock);
   endtask

   // three header words of one node
   task automatic send_header(input logic [TypeWidth-1:0] ty, input logic [31:0] len,
                              input logic first);
      send_word({32'($urandom), HdrMagic}, first);
      send_word({$urandom, $urandom}, 1'b0);
      send_word(len_word(ty, len), 1'b0);
   endtask

   // stop offering and let every predicted report drain
   task automatic wait_idle();
      int spins;
      req_valid <= 1'b0;
      @(posedge clock);
      spins = 0;
      while (sb.pending() != 0 && spins < 20000) begin
         @(posedge clock);
         spins++;
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_block_bytes(input logic [LenWidth-1:0] value);
      csr_valid       <= 1'b1;
      csr_block_bytes <= value;
      @(posedge clock);
      while (!(csr_valid && csr_ready)) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // random block: mostly node chains, some broken headers and noise
   function automatic void fill_block(ref logic [63:0] words[$], input int limit);
      int                   pick;
      int                   pad;
      logic [31:0]          len;
      logic [TypeWidth-1:0] ty;
      int                   near_limit[8] = '{24, 47, 48, 55, 56, 159, 160, 161};
      while (words.size() < limit) begin
         pick = $urandom_range(0, 9);
         case ($urandom_range(0, 3))
            0:       ty = TypeInode;
            1:       ty = TypeData;
            2:       ty = TypeDentry;
            default: ty = 8'($urandom);
         endcase
         if (pick < 7) begin
            if ($urandom_range(0, 3) == 0) begin
               len = 32'(near_limit[$urandom_range(0, 7)]);
            end else begin
               len = $urandom_range(24, 200);
            end
            words.push_back({32'($urandom), HdrMagic});
            words.push_back({$urandom, $urandom});
            words.push_back(len_word(ty, len));
            pad = (int'(len) + 7) / 8 - 3;
            repeat (pad) words.push_back({$urandom, $urandom});
         end else if (pick == 7) begin
            // broken header: corrupted magic, short length or runaway length
            case ($urandom_range(0, 2))
               0: begin
                  words.push_back({32'($urandom), HdrMagic ^ (32'd1 << $urandom_range(0, 31))});
                  len = $urandom_range(24, 200);
               end
               1: begin
                  words.push_back({32'($urandom), HdrMagic});
                  len = $urandom_range(0, 23);
               end
               default: begin
                  words.push_back({32'($urandom), HdrMagic});
                  len = $urandom;
               end
            endcase
            words.push_back({$urandom, $urandom});
            words.push_back(len_word(ty, len));
         end else begin
            words.push_back({$urandom, $urandom});
         end
      end
   endfunction

   initial begin : stimulus
      logic [63:0]         words[$];
      logic [LenWidth-1:0] phase_bytes[6];
      int                  sent;
      int                  limit;

      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_data_word   <= '0;
      req_block_start <= 1'b0;
      csr_valid       <= 1'b0;
      csr_block_bytes <= '0;
      idle_on  = 1'b1;
      hold_rsp = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // stream opens without a block start, inode right at its threshold
      send_word({32'hFFFF_FFFF, HdrMagic}, 1'b0);
      send_word('1, 1'b0);
      send_word(len_word(TypeInode, 160), 1'b0);
      // data and dentry at their thresholds, inode one byte short
      send_header(TypeData, 48, 1'b1);
      send_header(TypeDentry, 56, 1'b1);
      send_header(TypeInode, 159, 1'b1);
      // failed magic advances one word, then widest type and shortest length
      send_word({32'($urandom), HdrMagic ^ 32'h1}, 1'b1);
      send_word({32'($urandom), HdrMagic}, 1'b0);
      send_word(64'd0, 1'b0);
      send_word(len_word(8'hFF, 24), 1'b0);
      // length below the header size, then an all-ones length that cannot fit
      send_header(TypeData, 23, 1'b1);
      send_header(TypeDentry, 32'hFFFF_FFFF, 1'b1);
      wait_idle();

      // smallest block: only the header at offset zero fits
      write_block_bytes(22'd24);
      send_header(TypeData, 24, 1'b1);
      send_header(TypeData, 24, 1'b0);
      wait_idle();

      // oversized block: the skip target pins at the top and blocks the rest
      write_block_bytes(22'h3F_FFFF);
      send_header(TypeDentry, 32'h003F_FFFF, 1'b1);
      send_header(TypeInode, 24, 1'b0);
      send_header(TypeInode, 24, 1'b0);
      wait_idle();

      // full-size block: one node spans the whole block and hides what follows
      write_block_bytes(22'd2097152);
      send_header(TypeInode, 32'd2097152, 1'b1);
      send_header(TypeData, 48, 1'b0);
      wait_idle();

      phase_bytes[0] = DefaultBlockBytes;
      phase_bytes[1] = 22'($urandom_range(24, 512));
      phase_bytes[2] = 22'd2097152;
      phase_bytes[3] = 22'd24;
      phase_bytes[4] = 22'h3F_FFFF;
      phase_bytes[5] = 22'($urandom_range(600, 8192));

      for (int phase = 0; phase < 6; phase++) begin
         write_block_bytes(phase_bytes[phase]);
         sent = 0;
         if (phase == 0) begin
            // dense short nodes while the response side holds off
            idle_on  = 1'b0;
            hold_rsp = 1'b1;
            for (int k = 0; k < 40; k++) begin
               send_header(TypeData, 24, k == 0);
            end
            sent = 120;
         end
         while (sent < 110) begin
            idle_on = ($urandom_range(0, 3) != 0);
            if (phase_bytes[phase] / 8 < 56) begin
               limit = int'(phase_bytes[phase] / 8) + $urandom_range(1, 4);
            end else begin
               limit = $urandom_range(8, 60);
            end
            words.delete();
            fill_block(words, limit);
            foreach (words[i]) send_word(words[i], i == 0);
            sent += words.size();
         end
         idle_on = 1'b1;
         wait_idle();
      end

      repeat (8) @(posedge clock);
      if (sb.pending() != 0) begin
         $display("%0t: %0d expected node reports never arrived", $time, sb.pending());
      end
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // overall time limit
   initial begin : watchdog
      #(12 * 1_500_000);
      $display("CHECK FAILED");
      $finish;
   end

endmodule
